// ----- design/ipacl_pkg.sv -----
// Shared types, operation codes and helpers for the IPv4 prefix access list.
`timescale 1ns / 1ps
`default_nettype none

package ipacl_pkg;

    localparam logic [1:0] FUNC_CHECK  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic CFG_BYPASS_ADDRESS  = 1'b0;
    localparam logic CFG_DEFAULT_VERDICT = 1'b1;

    localparam logic [31:0] BYPASS_RESET  = 32'h7f00_0001;
    localparam logic        VERDICT_RESET = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [5:0]  prefix_length;
        logic        allow;
    } t_acl_in;

    typedef struct packed {
        logic       verdict;
        logic       rule_matched;
        logic [5:0] match_index;
        logic       table_full_error;
        logic [6:0] rules_held;
    } t_acl_out;

    // Compare result for one stored rule, valid in the cycle after its read is issued.
    typedef struct packed {
        logic vld;
        logic hit;
        logic allow;
    } t_hit;

    // Lengths above 32 saturate to a full mask; length zero gives an empty mask.
    function automatic logic [31:0] prefix_to_mask(input logic [5:0] len);
        logic [5:0] sat;
        sat = (len > 6'd32) ? 6'd32 : len;
        if (sat == 6'd0) begin
            return 32'h0;
        end
        return 32'hffff_ffff << (6'd32 - sat);
    endfunction

endpackage

`default_nettype wire

// ----- design/ip_prefix_acl_first_match.sv -----
// Append, clear and bypass or empty-table checks pass their result through the pending register
// to the output register. A check that walks the table reads one rule per cycle from the rule
// memory, which has separate write and read ports; the walk stops at the first matching rule.
// One operation at a time: a new transfer is taken once the previous result is queued in the
// output register, which happens only when that register is free or being read.
// Synchronous active-low reset empties the table and restores the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module ip_prefix_acl_first_match #(
    parameter int MAX_RULES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ipacl_pkg::t_acl_in   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output ipacl_pkg::t_acl_out       o_out_data
);
    import ipacl_pkg::*;

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_addr, n_rd_addr;
    logic [31:0]   r_bypass;
    logic          r_default;
    logic [31:0]   r_key, n_key;
    t_acl_out      r_pend, n_pend;
    t_acl_out      r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          in_fire;
    logic          full;
    logic          wr_en;
    logic          rd_en;
    t_hit          hit;
    logic [AW-1:0] hit_idx;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign full        = (r_count == CW'(MAX_RULES));
    assign wr_en       = in_fire && (i_in_data.func == FUNC_APPEND) && !full;
    assign rd_en       = (r_state == ST_SCAN) && (r_rd_addr < r_count);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    ipacl_rule_table #(
        .MAX_RULES (MAX_RULES),
        .AW        (AW)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_idx     (r_count[AW-1:0]),
        .i_wr_address (i_in_data.address),
        .i_wr_prefix  (i_in_data.prefix_length),
        .i_wr_allow   (i_in_data.allow),
        .i_rd_en      (rd_en),
        .i_rd_idx     (r_rd_addr[AW-1:0]),
        .i_key        (r_key),
        .o_hit        (hit),
        .o_hit_idx    (hit_idx)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_addr   = r_rd_addr;
        n_key       = r_key;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_key     = i_in_data.address;
                    n_rd_addr = '0;
                    n_pend    = '0;
                    n_pend.rules_held = 7'(r_count);
                    n_state   = ST_DONE;
                    case (i_in_data.func)
                        FUNC_CHECK: begin
                            if (i_in_data.address == r_bypass) begin
                                n_pend.verdict = 1'b1;
                            end else if (r_count == '0) begin
                                n_pend.verdict = r_default;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        FUNC_APPEND: begin
                            if (full) begin
                                n_pend.table_full_error = 1'b1;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_pend.rules_held = 7'(r_count + CW'(1));
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count = '0;
                            n_pend.rules_held = 7'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_rd_addr = r_rd_addr + CW'(1);
                end
                if (hit.vld) begin
                    if (hit.hit) begin
                        n_pend.verdict      = hit.allow;
                        n_pend.rule_matched = 1'b1;
                        n_pend.match_index  = 6'(hit_idx);
                        n_state             = ST_DONE;
                    end else if (CW'(hit_idx) == r_count - CW'(1)) begin
                        n_pend.verdict = r_default;
                        n_state        = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // Move the result to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_addr   <= '0;
            r_bypass    <= BYPASS_RESET;
            r_default   <= VERDICT_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rd_addr   <= n_rd_addr;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BYPASS_ADDRESS:  r_bypass  <= i_cfg_data;
                    CFG_DEFAULT_VERDICT: r_default <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

// ----- design/ipacl_rule_table.sv -----
// Rule memory with registered read and the masked-address comparator.
`timescale 1ns / 1ps
`default_nettype none

module ipacl_rule_table #(
    parameter int MAX_RULES = 64,
    parameter int AW        = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_idx,
    input  wire logic [31:0]     i_wr_address,
    input  wire logic [5:0]      i_wr_prefix,
    input  wire logic            i_wr_allow,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_idx,
    input  wire logic [31:0]     i_key,
    output ipacl_pkg::t_hit      o_hit,
    output logic [AW-1:0]        o_hit_idx
);
    import ipacl_pkg::*;

    // Entry layout: allow, mask, masked address.
    logic [64:0]   mem [MAX_RULES];
    logic [64:0]   r_rdata;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic [31:0]   wr_mask;

    assign wr_mask = prefix_to_mask(i_wr_prefix);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= {i_wr_allow, wr_mask, i_wr_address & wr_mask};
        end
        if (i_rd_en) begin
            r_rdata  <= mem[i_rd_idx];
            r_rd_idx <= i_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
        end
    end

    always_comb begin
        o_hit.vld   = r_rd_vld;
        o_hit.hit   = (i_key & r_rdata[63:32]) == r_rdata[31:0];
        o_hit.allow = r_rdata[64];
    end

    assign o_hit_idx = r_rd_idx;

endmodule

`default_nettype wire

// ----- dv/tb_ip_prefix_acl_first_match.sv -----
// Self-checking testbench for the first-match IPv4 prefix access list.
`timescale 1ns / 1ps
`default_nettype none

module tb_ip_prefix_acl_first_match;
    import ipacl_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int TABLE_DEPTH  = 64;
    localparam int LONG_HOLD    = 400;
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_acl_in     i_in_data  = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_acl_out    o_out_data;

    ip_prefix_acl_first_match u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the rule table, advanced on every input transfer, and of the configuration registers.
    logic [31:0] acl_addr  [TABLE_DEPTH];
    logic [31:0] acl_mask  [TABLE_DEPTH];
    logic        acl_allow [TABLE_DEPTH];
    int unsigned acl_count   = 0;
    logic [31:0] cfg_bypass  = BYPASS_RESET;
    logic        cfg_default = VERDICT_RESET;

    // Rules as the stimulus generator expects them, used to aim checks at real prefixes.
    logic [31:0] plan_addr [$];
    logic [5:0]  plan_len  [$];
    logic [31:0] addr_pool [8];

    t_acl_in  pending_ops [$];
    t_acl_out expected_verdicts [$];

    bit in_took = 1'b0;
    bit idle_on = 1'b0;
    int send_gap = 0;
    int out_stall = 0;
    int long_hold_reqs = 0;
    int long_hold_served = 0;
    int stuck_cycles = 0;
    int failures = 0;
    int n_checks = 0, n_hits = 0, n_bypass = 0;
    int n_appends = 0, n_full = 0, n_clears = 0, n_unused = 0;
    t_acl_out want;

    function automatic logic [31:0] len_mask(input logic [5:0] len);
        int n;
        n = (len > 6'd32) ? 32 : int'(len);
        return (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - n));
    endfunction

    function automatic t_acl_out acl_result(input t_acl_in op);
        t_acl_out    res;
        logic [31:0] m;
        int          i;
        res = '0;
        case (op.func)
            FUNC_CHECK: begin
                n_checks++;
                if (op.address == cfg_bypass) begin
                    res.verdict = 1'b1;
                    n_bypass++;
                end else begin
                    res.verdict = cfg_default;
                    i = 0;
                    while (i < int'(acl_count) && !res.rule_matched) begin
                        if ((op.address & acl_mask[i]) == acl_addr[i]) begin
                            res.verdict      = acl_allow[i];
                            res.rule_matched = 1'b1;
                            res.match_index  = 6'(i);
                        end
                        i++;
                    end
                    if (res.rule_matched) begin
                        n_hits++;
                    end
                end
            end
            FUNC_APPEND: begin
                n_appends++;
                if (acl_count >= TABLE_DEPTH) begin
                    res.table_full_error = 1'b1;
                    n_full++;
                end else begin
                    m = len_mask(op.prefix_length);
                    acl_mask[acl_count]  = m;
                    acl_addr[acl_count]  = op.address & m;
                    acl_allow[acl_count] = op.allow;
                    acl_count++;
                end
            end
            FUNC_CLEAR: begin
                n_clears++;
                acl_count = 0;
            end
            default: begin
                n_unused++;
            end
        endcase
        res.rules_held = 7'(acl_count);
        return res;
    endfunction

    function automatic t_acl_in next_random_op();
        t_acl_in     op;
        int          r;
        int          k;
        logic [31:0] m;
        op.func          = FUNC_CHECK;
        op.address       = $urandom();
        op.prefix_length = 6'($urandom_range(0, 63));
        op.allow         = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 999);
        if (r < 6) begin
            op.func = FUNC_CLEAR;
            plan_addr.delete();
            plan_len.delete();
        end else if (r < 14) begin
            op.func = FUNC_UNUSED;
        end else if (r < 450) begin
            op.func    = FUNC_APPEND;
            op.address = addr_pool[$urandom_range(0, 7)] ^ ($urandom() >> $urandom_range(8, 32));
            r = $urandom_range(0, 199);
            // A zero length matches everything and hides the rest of the table, so keep it rare.
            if (r == 0) begin
                op.prefix_length = 6'd0;
            end else if (r < 8) begin
                op.prefix_length = 6'($urandom_range(33, 63));
            end else if (r < 14) begin
                op.prefix_length = 6'($urandom_range(1, 15));
            end else begin
                op.prefix_length = 6'($urandom_range(16, 32));
            end
            if (plan_addr.size() < TABLE_DEPTH) begin
                plan_addr.push_back(op.address);
                plan_len.push_back(op.prefix_length);
            end
        end else begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                op.address = cfg_bypass;
            end else if (r < 65 && plan_addr.size() != 0) begin
                k = $urandom_range(0, plan_addr.size() - 1);
                m = len_mask(plan_len[k]);
                op.address = (plan_addr[k] & m) | ($urandom() & ~m);
            end else if (r < 80) begin
                op.address = addr_pool[$urandom_range(0, 7)] ^ ($urandom() >> $urandom_range(4, 32));
            end
        end
        return op;
    endfunction

    task automatic push_op(input logic [1:0] func, input logic [31:0] addr,
                           input logic [5:0] len, input logic allow);
        t_acl_in op;
        op.func          = func;
        op.address       = addr;
        op.prefix_length = len;
        op.allow         = allow;
        pending_ops.push_back(op);
    endtask

    task automatic push_random(input int count);
        repeat (count) pending_ops.push_back(next_random_op());
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_in_valid || expected_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BYPASS_ADDRESS) begin
            cfg_bypass = data;
        end else begin
            cfg_default = data[0];
        end
    endtask

    // Sender: a new item goes out once the previous one has been transferred, with random gaps now and then.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_took) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                i_in_data  <= pending_ops.pop_front();
                i_in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 13);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold when one is requested.
    always @(negedge i_clk) begin
        if (long_hold_served != long_hold_reqs) begin
            long_hold_served = long_hold_reqs;
            out_stall = LONG_HOLD;
        end else if (out_stall == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            out_stall = $urandom_range(1, 13);
        end
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                expected_verdicts.push_back(acl_result(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("Unexpected result at %0t: verdict=%0b matched=%0b index=%0d",
                                 $realtime, o_out_data.verdict, o_out_data.rule_matched,
                                 o_out_data.match_index);
                    end
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_out_data.verdict !== want.verdict
                            || o_out_data.rule_matched !== want.rule_matched
                            || o_out_data.match_index !== want.match_index
                            || o_out_data.table_full_error !== want.table_full_error
                            || o_out_data.rules_held !== want.rules_held) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("Mismatch at %0t: expected v=%0b m=%0b idx=%0d full=%0b held=%0d",
                                     $realtime, want.verdict, want.rule_matched,
                                     want.match_index, want.table_full_error, want.rules_held);
                            $display("                 got      v=%0b m=%0b idx=%0d full=%0b held=%0d",
                                     o_out_data.verdict, o_out_data.rule_matched,
                                     o_out_data.match_index, o_out_data.table_full_error,
                                     o_out_data.rules_held);
                        end
                    end
                end
            end
            // Watchdog: only counts while work is outstanding.
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (pending_ops.size() == 0 && !i_in_valid
                        && expected_verdicts.size() == 0)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles with work outstanding",
                         STUCK_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] junk;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hffff_ffff;
        addr_pool[2] = 32'h0a00_0000;
        addr_pool[3] = 32'hc0a8_0000;
        for (int i = 4; i < 8; i++) begin
            addr_pool[i] = $urandom();
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        // Directed part with the reset register values.
        push_op(FUNC_CHECK,  32'h7f00_0001, 6'd0,  1'b0);   // bypass on an empty table
        push_op(FUNC_CHECK,  32'h0000_0000, 6'd0,  1'b0);
        push_op(FUNC_CHECK,  32'hffff_ffff, 6'd63, 1'b1);
        push_op(FUNC_APPEND, 32'h0a12_3456, 6'd8,  1'b0);   // host bits must be masked off
        push_op(FUNC_APPEND, 32'h0a01_0000, 6'd16, 1'b1);   // shadowed by the /8 above
        push_op(FUNC_APPEND, 32'hc0a8_0105, 6'd32, 1'b1);
        push_op(FUNC_APPEND, 32'hffff_ffff, 6'd33, 1'b0);   // saturates to a full mask
        push_op(FUNC_APPEND, 32'h0000_0000, 6'd63, 1'b1);
        push_op(FUNC_CHECK,  32'h0a01_0203, 6'd0,  1'b1);
        push_op(FUNC_CHECK,  32'hc0a8_0105, 6'd0,  1'b0);
        push_op(FUNC_CHECK,  32'hc0a8_0104, 6'd0,  1'b0);
        push_op(FUNC_CHECK,  32'hffff_ffff, 6'd0,  1'b0);
        push_op(FUNC_CHECK,  32'h0000_0000, 6'd0,  1'b0);
        push_op(FUNC_UNUSED, 32'hffff_ffff, 6'd63, 1'b1);
        push_op(FUNC_APPEND, 32'h1234_5678, 6'd0,  1'b0);   // empty mask matches everything
        push_op(FUNC_CHECK,  32'h7f00_0001, 6'd0,  1'b0);   // bypass wins over a matching rule
        push_op(FUNC_CHECK,  32'h8000_0000, 6'd0,  1'b0);
        push_op(FUNC_CLEAR,  32'hffff_ffff, 6'd63, 1'b1);
        push_op(FUNC_CHECK,  32'h0a01_0203, 6'd0,  1'b0);
        push_op(FUNC_APPEND, 32'h8000_0000, 6'd1,  1'b1);
        push_op(FUNC_CHECK,  32'hffff_fffe, 6'd0,  1'b0);
        wait_drained();

        junk = $urandom();
        write_reg(CFG_BYPASS_ADDRESS, $urandom());
        write_reg(CFG_DEFAULT_VERDICT, {junk[31:1], 1'b0});
        push_random(450);
        wait_drained();

        // The receiver holds off while the sender keeps offering, then the sender
        // pauses until every result is back.
        junk = $urandom();
        write_reg(CFG_BYPASS_ADDRESS, 32'h0000_0000);
        write_reg(CFG_DEFAULT_VERDICT, {junk[31:1], 1'b1});
        long_hold_reqs++;
        push_random(200);
        wait_drained();
        push_random(200);
        wait_drained();

        junk = $urandom();
        write_reg(CFG_BYPASS_ADDRESS, 32'hffff_ffff);
        write_reg(CFG_DEFAULT_VERDICT, {junk[31:1], 1'b0});
        push_random(300);
        wait_drained();

        // Last stretch at full rate on both sides.
        idle_on = 1'b0;
        write_reg(CFG_BYPASS_ADDRESS, BYPASS_RESET);
        write_reg(CFG_DEFAULT_VERDICT, {31'd0, VERDICT_RESET});
        push_random(280);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_verdicts.size() != 0) begin
            failures += expected_verdicts.size();
            $display("%0d results never arrived", expected_verdicts.size());
        end
        $display("Covered %0d checks (%0d decided by a rule, %0d bypass hits), %0d appends",
                 n_checks, n_hits, n_bypass, n_appends);
        $display("(%0d dropped on a full table), %0d clears, %0d unused codes; %0d failures",
                 n_full, n_clears, n_unused, failures);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
